[design/scl_pkg.sv]
// shared types, character codes and helpers for the shell command lexer
`default_nettype none

package scl_pkg;

  // longest word before it is forced to end
  localparam int MAX_WORD_BYTES = 1023;
  localparam int LEN_W          = $clog2(MAX_WORD_BYTES + 1);

  // most results one input item can cause
  localparam int MAX_RESULTS = 4;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // character codes
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_TOKEN = 2'd1,
    KIND_EOL   = 2'd2
  } kind_t;

  // token types
  typedef enum logic [3:0] {
    TT_WORD   = 4'd0,
    TT_PIPE   = 4'd1,
    TT_OR     = 4'd2,
    TT_BG     = 4'd3,
    TT_AND    = 4'd4,
    TT_IN     = 4'd5,
    TT_OUT    = 4'd6,
    TT_APPEND = 4'd7,
    TT_SEMI   = 4'd8
  } tok_t;

  // operator waiting for its lookahead byte
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_PIPE = 2'd1,
    PEND_AMP  = 2'd2,
    PEND_GT   = 2'd3
  } pend_t;

  // one result item
  typedef struct packed {
    kind_t      kind;
    tok_t       ttype;
    logic [7:0] wbyte;
    logic       last;
  } res_t;

  // lexer state
  typedef struct packed {
    pend_t            pend;
    logic             in_word;
    logic             in_quote;
    logic             q_single;
    logic             esc;
    logic [LEN_W-1:0] len;
  } lex_state_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PIPE) || (c == CH_AMP) || (c == CH_LT) || (c == CH_GT) ||
           (c == CH_SEMI);
  endfunction

  // character that doubles a pending operator
  function automatic logic [7:0] pend_char(input pend_t p);
    unique case (p)
      PEND_PIPE: return CH_PIPE;
      PEND_AMP:  return CH_AMP;
      PEND_GT:   return CH_GT;
      default:   return 8'h00;
    endcase
  endfunction

  // single form of a pending operator
  function automatic tok_t pend_single(input pend_t p);
    unique case (p)
      PEND_PIPE: return TT_PIPE;
      PEND_AMP:  return TT_BG;
      PEND_GT:   return TT_OUT;
      default:   return TT_WORD;
    endcase
  endfunction

  // double form of a pending operator
  function automatic tok_t pend_double(input pend_t p);
    unique case (p)
      PEND_PIPE: return TT_OR;
      PEND_AMP:  return TT_AND;
      PEND_GT:   return TT_APPEND;
      default:   return TT_WORD;
    endcase
  endfunction

  function automatic res_t mk_res(input kind_t k, input tok_t t, input logic [7:0] b);
    res_t r;
    r.kind  = k;
    r.ttype = t;
    r.wbyte = b;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

[design/scl_if.sv]
// valid/ready channel interfaces for command bytes and lexer results
`default_nettype none

interface scl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       end_of_line;

  modport source (output valid, output byte_req, output end_of_line, input ready);
  modport sink   (input valid, input byte_req, input end_of_line, output ready);
endinterface

interface scl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [3:0] token_type;
  logic [7:0] word_byte;
  logic       last;

  modport source (output valid, output out_kind, output token_type, output word_byte,
                  output last, input ready);
  modport sink   (input valid, input out_kind, input token_type, input word_byte,
                  input last, output ready);
endinterface

`default_nettype wire

[design/shell_command_lexer_unit.sv]
// shell command lexer: byte stream in, word bytes and tokens out
//
// cmd carries one command-line byte per item, with end_of_line set on the
// last byte of each line. tok carries result items: word bytes, completed
// tokens (word or operator) and an end-of-line marker; last marks the final
// result caused by one input item, and a blank byte between tokens causes none.
// An accepted byte is lexed in the cycle it is taken; its up to four
// results are written into an eight-entry result queue that feeds tok.
// The queue sends one result per cycle while tok is ready. cmd accepts
// one byte per cycle while the queue has room for four more results, so
// one byte per cycle is sustained as long as tok is ready and bytes
// average no more than one result each; bytes that cause several results
// slow the input, as the single queue read port sends one result at a time.
// When tok stalls the queue fills and cmd.ready drops; nothing is lost.
// Reset (synchronous, active high) clears the lexer state and empties the
// queue.
`default_nettype none

module shell_command_lexer_unit
  import scl_pkg::*;
(
  input  wire            clk,
  input  wire            rst,
  scl_in_if.sink         cmd,
  scl_out_if.source      tok
);

  localparam int DEPTH = 8;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lex_state_t           st;
  lex_state_t           st_next;
  res_t                 res [MAX_RESULTS];
  logic [RES_CNT_W-1:0] n_res;

  res_t                 mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;

  logic                 push;
  logic                 pop;
  logic [7:0]           c;
  logic                 eol;

  assign c    = cmd.byte_req;
  assign eol  = cmd.end_of_line;
  assign push = cmd.valid && cmd.ready;
  assign pop  = tok.valid && tok.ready;

  // room for the worst case of one item
  assign cmd.ready = (count <= CNT_W'(DEPTH - MAX_RESULTS));

  // lex one byte against the current state
  always_comb begin
    logic idle;
    logic wstep;
    logic app;
    st_next = st;
    n_res   = '0;
    idle    = 1'b0;
    wstep   = 1'b0;
    app     = 1'b0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = mk_res(KIND_BYTE, TT_WORD, 8'h00);
    end

    // lookahead, word continuation or idle
    if (st_next.pend != PEND_NONE) begin
      if (c == pend_char(st_next.pend)) begin
        res[n_res[1:0]] = mk_res(KIND_TOKEN, pend_double(st_next.pend), 8'h00);
        n_res = n_res + 1'b1;
      end else begin
        res[n_res[1:0]] = mk_res(KIND_TOKEN, pend_single(st_next.pend), 8'h00);
        n_res = n_res + 1'b1;
        idle  = 1'b1;
      end
      st_next.pend = PEND_NONE;
    end else if (st_next.in_word) begin
      if (!st_next.esc && !st_next.in_quote && (is_blank(c) || is_op(c))) begin
        res[n_res[1:0]] = mk_res(KIND_TOKEN, TT_WORD, 8'h00);
        n_res = n_res + 1'b1;
        st_next.in_word  = 1'b0;
        st_next.in_quote = 1'b0;
        st_next.q_single = 1'b0;
        st_next.esc      = 1'b0;
        st_next.len      = '0;
        idle = 1'b1;
      end else begin
        wstep = 1'b1;
      end
    end else begin
      idle = 1'b1;
    end

    // idle: skip blanks, take operators, or start a word
    if (idle) begin
      if (is_blank(c)) begin
        wstep = 1'b0;
      end else if (c == CH_LT) begin
        res[n_res[1:0]] = mk_res(KIND_TOKEN, TT_IN, 8'h00);
        n_res = n_res + 1'b1;
      end else if (c == CH_SEMI) begin
        res[n_res[1:0]] = mk_res(KIND_TOKEN, TT_SEMI, 8'h00);
        n_res = n_res + 1'b1;
      end else if (c == CH_PIPE) begin
        st_next.pend = PEND_PIPE;
      end else if (c == CH_AMP) begin
        st_next.pend = PEND_AMP;
      end else if (c == CH_GT) begin
        st_next.pend = PEND_GT;
      end else begin
        st_next.in_word = 1'b1;
        st_next.len     = '0;
        wstep = 1'b1;
      end
    end

    // word byte: escape, quotes, plain byte
    if (wstep) begin
      if (st_next.esc) begin
        st_next.esc = 1'b0;
        app = 1'b1;
      end else if (st_next.in_quote) begin
        if (c == (st_next.q_single ? CH_SQUOTE : CH_DQUOTE)) begin
          st_next.in_quote = 1'b0;
          st_next.q_single = 1'b0;
        end else begin
          app = 1'b1;
        end
      end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
        st_next.in_quote = 1'b1;
        st_next.q_single = (c == CH_SQUOTE);
      end else if (c == CH_BSLASH) begin
        st_next.esc = 1'b1;
      end else begin
        app = 1'b1;
      end
    end

    // append with the length limit
    if (app) begin
      res[n_res[1:0]] = mk_res(KIND_BYTE, TT_WORD, c);
      n_res = n_res + 1'b1;
      st_next.len = st_next.len + LEN_W'(1);
      if (st_next.len >= LEN_W'(MAX_WORD_BYTES)) begin
        res[n_res[1:0]] = mk_res(KIND_TOKEN, TT_WORD, 8'h00);
        n_res = n_res + 1'b1;
        st_next.in_word  = 1'b0;
        st_next.in_quote = 1'b0;
        st_next.q_single = 1'b0;
        st_next.esc      = 1'b0;
        st_next.len      = '0;
      end
    end

    // end of line: flush operator, close word, marker
    if (eol) begin
      if (st_next.pend != PEND_NONE) begin
        res[n_res[1:0]] = mk_res(KIND_TOKEN, pend_single(st_next.pend), 8'h00);
        n_res = n_res + 1'b1;
      end
      if (st_next.in_word) begin
        res[n_res[1:0]] = mk_res(KIND_TOKEN, TT_WORD, 8'h00);
        n_res = n_res + 1'b1;
      end
      st_next = '0;
      res[n_res[1:0]] = mk_res(KIND_EOL, TT_WORD, 8'h00);
      n_res = n_res + 1'b1;
    end

    // mark the final result of the item
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i].last = (n_res == RES_CNT_W'(i + 1));
    end
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (push) begin
      st <= st_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (n_res > RES_CNT_W'(i)) begin
          mem[wr_ptr + PTR_W'(i)] <= res[i];
        end
      end
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (push ? CNT_W'(n_res) : CNT_W'(0)) - (pop ? CNT_W'(1) : CNT_W'(0));
    end
  end

  // result channel
  assign tok.valid      = (count != '0);
  assign tok.out_kind   = mem[rd_ptr].kind;
  assign tok.token_type = mem[rd_ptr].ttype;
  assign tok.word_byte  = mem[rd_ptr].wbyte;
  assign tok.last       = mem[rd_ptr].last;

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("result queue overfilled");

  // every accepted item stays within the result limit, and an end-of-line byte always yields a result
  assert property (@(posedge clk) disable iff (rst)
    push |-> (n_res <= RES_CNT_W'(MAX_RESULTS)) && (!eol || (n_res != '0)))
    else $error("bad result count for an item");

  // the end-of-line marker closes the results of its item
  assert property (@(posedge clk) disable iff (rst)
    (tok.valid && (tok.out_kind == KIND_EOL)) |-> tok.last)
    else $error("end-of-line result not marked last");

  // a just-accepted end-of-line byte leaves the lexer idle
  assert property (@(posedge clk) disable iff (rst)
    (push && eol) |=> (st == '0))
    else $error("lexer state not cleared at end of line");

endmodule

`default_nettype wire

[test/tb_shell_command_lexer_unit.sv]
// testbench for the shell command lexer: byte lines in, checked token stream out
module tb_shell_command_lexer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import scl_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 112;
  localparam int SETTLE_CYCLES = 20;
  localparam int REPORT_MAX    = 10;

  // expected token stream, built by lexing every accepted byte
  class token_scoreboard;
    pend_t       pend = PEND_NONE;
    bit          in_word;
    bit          in_quote;
    bit          q_single;
    bit          esc;
    int unsigned wlen;
    res_t        batch[$];
    res_t        expected_tokens[$];
    int          mismatches;

    static function bit is_space_char(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    static function bit is_operator_char(logic [7:0] c);
      return (c == CH_PIPE) || (c == CH_AMP) || (c == CH_LT) || (c == CH_GT) ||
             (c == CH_SEMI);
    endfunction

    function void emit(kind_t k, tok_t t, logic [7:0] b);
      res_t r;
      r.kind  = k;
      r.ttype = t;
      r.wbyte = b;
      r.last  = 1'b0;
      batch.push_back(r);
    endfunction

    // word token done, quote and escape state dropped
    function void end_word();
      emit(KIND_TOKEN, TT_WORD, 8'h00);
      in_word  = 1'b0;
      in_quote = 1'b0;
      q_single = 1'b0;
      esc      = 1'b0;
      wlen     = 0;
    endfunction

    // byte goes out, word ends once it hits the length limit
    function void add_byte(logic [7:0] c);
      emit(KIND_BYTE, TT_WORD, c);
      wlen++;
      if (wlen >= MAX_WORD_BYTES) end_word();
    endfunction

    // byte inside a word: escapes and quotes
    function void word_char(logic [7:0] c);
      if (esc) begin
        esc = 1'b0;
        add_byte(c);
      end else if (in_quote) begin
        if (c == (q_single ? CH_SQUOTE : CH_DQUOTE)) begin
          in_quote = 1'b0;
          q_single = 1'b0;
        end else begin
          add_byte(c);
        end
      end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
        in_quote = 1'b1;
        q_single = (c == CH_SQUOTE);
      end else if (c == CH_BSLASH) begin
        esc = 1'b1;
      end else begin
        add_byte(c);
      end
    endfunction

    // byte seen between tokens
    function void idle_char(logic [7:0] c);
      if (is_space_char(c)) return;
      if (c == CH_LT) emit(KIND_TOKEN, TT_IN, 8'h00);
      else if (c == CH_SEMI) emit(KIND_TOKEN, TT_SEMI, 8'h00);
      else if (c == CH_PIPE) pend = PEND_PIPE;
      else if (c == CH_AMP) pend = PEND_AMP;
      else if (c == CH_GT) pend = PEND_GT;
      else begin
        in_word = 1'b1;
        wlen    = 0;
        word_char(c);
      end
    endfunction

    // pending operator goes out in its single form
    function void flush_pending();
      case (pend)
        PEND_PIPE: emit(KIND_TOKEN, TT_PIPE, 8'h00);
        PEND_AMP:  emit(KIND_TOKEN, TT_BG, 8'h00);
        PEND_GT:   emit(KIND_TOKEN, TT_OUT, 8'h00);
        default: ;
      endcase
      pend = PEND_NONE;
    endfunction

    function void note_byte(logic [7:0] c, logic eol);
      logic [7:0] dbl_char;
      tok_t       dbl_tok;
      batch.delete();
      if (pend != PEND_NONE) begin
        case (pend)
          PEND_PIPE: begin dbl_char = CH_PIPE; dbl_tok = TT_OR; end
          PEND_AMP:  begin dbl_char = CH_AMP;  dbl_tok = TT_AND; end
          default:   begin dbl_char = CH_GT;   dbl_tok = TT_APPEND; end
        endcase
        if (c == dbl_char) begin
          emit(KIND_TOKEN, dbl_tok, 8'h00);
          pend = PEND_NONE;
        end else begin
          flush_pending();
          idle_char(c);
        end
      end else if (in_word) begin
        if (!esc && !in_quote && (is_space_char(c) || is_operator_char(c))) begin
          end_word();
          idle_char(c);
        end else begin
          word_char(c);
        end
      end else begin
        idle_char(c);
      end
      // line end: close everything, then the marker
      if (eol) begin
        flush_pending();
        if (in_word) end_word();
        in_word  = 1'b0;
        in_quote = 1'b0;
        q_single = 1'b0;
        esc      = 1'b0;
        wlen     = 0;
        emit(KIND_EOL, TT_WORD, 8'h00);
      end
      if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) expected_tokens.push_back(batch[i]);
    endfunction

    function void check_token(logic [1:0] k, logic [3:0] t, logic [7:0] b, logic l);
      res_t want;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: kind=%0d type=%0d byte=%02h last=%0d", k, t, b, l);
        return;
      end
      want = expected_tokens.pop_front();
      if ((k !== want.kind) || (t !== want.ttype) || (b !== want.wbyte) ||
          (l !== want.last)) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("result mismatch: expected kind=%0d type=%0d byte=%02h last=%0d",
                   want.kind, want.ttype, want.wbyte, want.last);
          $display("                 got      kind=%0d type=%0d byte=%02h last=%0d",
                   k, t, b, l);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  scl_in_if  cmd_ch();
  scl_out_if tok_ch();

  shell_command_lexer_unit u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .tok (tok_ch)
  );

  token_scoreboard sb = new();

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_asked;
  int hold_taken;
  int hold_left;
  int bytes_sent;
  int quiet_cycles;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // accepted items on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) sb.note_byte(cmd_ch.byte_req, cmd_ch.end_of_line);
      if (tok_ch.valid && tok_ch.ready)
        sb.check_token(tok_ch.out_kind, tok_ch.token_type, tok_ch.word_byte, tok_ch.last);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    tok_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        tok_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left  = HOLD_CYCLES;
        tok_ch.ready <= 1'b0;
      end else begin
        tok_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", quiet_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] blank_char();
    return $urandom_range(1) ? CH_SPACE : 8'($urandom_range(CH_CR, CH_TAB));
  endfunction

  // byte that is neither blank, operator, quote nor backslash
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1));
    while (token_scoreboard::is_space_char(c) || token_scoreboard::is_operator_char(c) ||
           (c == CH_SQUOTE) || (c == CH_DQUOTE) || (c == CH_BSLASH));
    return c;
  endfunction

  // any byte, leaning toward the ones the lexer treats specially
  function automatic logic [7:0] noisy_char();
    if ($urandom_range(2) != 0) return 8'($urandom_range(255, 1));
    case ($urandom_range(8))
      0:       return CH_PIPE;
      1:       return CH_AMP;
      2:       return CH_LT;
      3:       return CH_GT;
      4:       return CH_SEMI;
      5:       return CH_DQUOTE;
      6:       return CH_SQUOTE;
      7:       return CH_BSLASH;
      default: return blank_char();
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, logic eol);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.byte_req    <= b;
    cmd_ch.end_of_line <= eol;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line(logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // sender stops until every expected result is out
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_tokens.size() != 0) @(posedge clk);
  endtask

  // words that run into the length limit
  task automatic send_long_word(int variant);
    logic [7:0] q[$];
    logic [7:0] c;
    case (variant)
      0: begin
        repeat (MAX_WORD_BYTES) q.push_back(plain_char());
        q.push_back(CH_PIPE);
        q.push_back("x");
      end
      1: begin
        // escaped byte lands exactly on the limit
        repeat (MAX_WORD_BYTES - 1) q.push_back(plain_char());
        q.push_back(CH_BSLASH);
        q.push_back(CH_PIPE);
        q.push_back("a");
      end
      default: begin
        // limit reached inside quotes, the closing quote opens a new one
        q.push_back(CH_DQUOTE);
        repeat (MAX_WORD_BYTES) begin
          do c = 8'($urandom_range(255, 1)); while (c == CH_DQUOTE);
          q.push_back(c);
        end
        q.push_back(CH_DQUOTE);
        q.push_back("z");
      end
    endcase
    send_line(q);
  endtask

  // mostly well-formed command lines, some noise and broken endings
  task automatic send_random_line();
    logic [7:0] q[$];
    logic [7:0] closer;
    logic [7:0] c;
    int         n;
    if ($urandom_range(4) == 0) begin
      n = $urandom_range(12, 1);
      repeat (n) q.push_back(noisy_char());
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) begin
        if ($urandom_range(1)) q.push_back(blank_char());
        case ($urandom_range(5))
          0: begin
            case ($urandom_range(7))
              0: q.push_back(CH_PIPE);
              1: begin q.push_back(CH_PIPE); q.push_back(CH_PIPE); end
              2: q.push_back(CH_AMP);
              3: begin q.push_back(CH_AMP); q.push_back(CH_AMP); end
              4: q.push_back(CH_LT);
              5: q.push_back(CH_GT);
              6: begin q.push_back(CH_GT); q.push_back(CH_GT); end
              default: q.push_back(CH_SEMI);
            endcase
          end
          1: begin
            closer = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
            q.push_back(closer);
            repeat ($urandom_range(5)) begin
              do c = 8'($urandom_range(255, 1)); while (c == closer);
              q.push_back(c);
            end
            q.push_back(closer);
          end
          default: begin
            repeat ($urandom_range(6, 1)) begin
              if ($urandom_range(7) == 0) begin
                q.push_back(CH_BSLASH);
                q.push_back(8'($urandom_range(255, 1)));
              end else begin
                q.push_back(plain_char());
              end
            end
          end
        endcase
      end
      // line cut off in an escape or a quote
      case ($urandom_range(9))
        0: q.push_back(CH_BSLASH);
        1: q.push_back(CH_DQUOTE);
        default: ;
      endcase
    end
    send_line(q);
  endtask

  initial begin
    int base;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.byte_req    <= CH_SPACE;
    cmd_ch.end_of_line <= 1'b0;
    rst                <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // every operator, single and double, with lookahead flushes
    send_text("||&&>><;|&> ");
    // empty quoted word, escaped pipe, high and low bytes, open quote at line end
    send_text("\"\"\t\\|\013\377\001'");
    // backslash literal in quotes, lone trailing backslash
    send_text("'\\\"' \"\\'\" x\\");
    // pending operator flushed by a quote, then pending at line end
    send_text(">\"");
    send_text("&");
    // non-blank control bytes, blank last byte
    send_text("\016\200\015");

    for (int v = 0; v < 3; v++) send_long_word(v);
    wait_drained();

    // long receiver hold-off while the sender keeps pushing
    hold_asked++;
    repeat (47) send_byte(plain_char(), 1'b0);
    send_byte(plain_char(), 1'b1);
    wait_drained();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 74; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 74; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      base = bytes_sent;
      while (bytes_sent - base < PHASE_ITEMS) send_random_line();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_tokens.size() != 0) begin
      sb.mismatches++;
      $display("%0d expected results never arrived", sb.expected_tokens.size());
    end
    if (sb.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
